// ===== hdl/nshh_pkg.sv =====
// Shared types, constants and helpers of the NTC thermometer.
package nshh_pkg;

    localparam int FILTER_DEPTH_DEF = 8;
    localparam int ADC_BITS_DEF     = 12;

    localparam int COEFF_W = 48;
    localparam int OPC_W   = 24;
    localparam int OFS_W   = 16;
    localparam int TEMP_W  = 16;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;

    localparam int DVD_W   = 71;
    localparam int QUO_W   = 41;
    localparam int STEP_W  = 7;
    localparam int SH_W    = 7;
    localparam int LN_W    = 30;
    localparam int SQ_W    = 34;
    localparam int S_W     = 59;
    localparam int X_W     = 31;
    localparam int FRAC_W  = 24;
    localparam int SQR_ITER = 24;
    localparam int KX_W    = 46;

    localparam logic [OPC_W-1:0] OPC_RESET  = 24'd414312;
    localparam logic [63:0]      LN2_Q30    = 64'd744261118;
    localparam logic [QUO_W-1:0] K_CLAMP    = 41'h100_0000_0000;
    localparam logic [KX_W-1:0]  KELV_Q24   = 46'd27315 << 23;
    localparam logic [STEP_W-1:0] RECIP_STEPS = 7'd71;

    localparam logic [SH_W-1:0] SH_NONE = 7'd0;
    localparam logic [SH_W-1:0] SH_Q24  = 7'd24;
    localparam logic [SH_W-1:0] SH_Q30  = 7'd30;

    typedef enum logic [IDX_W-1:0] {
        CFG_COEFF_A        = 3'd0,
        CFG_COEFF_B        = 3'd1,
        CFG_COEFF_C        = 3'd2,
        CFG_OHMS_PER_COUNT = 3'd3,
        CFG_OFFSET_TENTHS  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff_a;
        logic signed [COEFF_W-1:0] coeff_b;
        logic signed [COEFF_W-1:0] coeff_c;
        logic [OPC_W-1:0]          ohms_per_count;
        logic signed [OFS_W-1:0]   offset_tenths;
    } t_cfg;

    typedef struct packed {
        logic               go;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [SH_W-1:0]    sh;
    } t_mul_req;

    typedef struct packed {
        logic              go;
        logic [DVD_W-1:0]  dvd;
        logic [63:0]       dsr;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_ACC,
        M_FIN
    } t_mul_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_RMUL,
        ST_NORM,
        ST_SQR,
        ST_LN,
        ST_SQ,
        ST_CSQ,
        ST_SLN,
        ST_DIV,
        ST_TEMP,
        ST_FIN
    } t_state;

    function automatic logic [63:0] nshh_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// ===== hdl/nshh_sample_if.sv =====
// Input channel carrying one raw converter sample per transfer.
interface nshh_sample_if #(
    parameter int ADC_BITS = nshh_pkg::ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== hdl/nshh_result_if.sv =====
// Output channel carrying one temperature result per transfer.
interface nshh_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] temp_tenths;
    logic        out_of_range;

    modport source (output valid, output temp_tenths, output out_of_range, input ready);
    modport sink   (input valid, input temp_tenths, input out_of_range, output ready);
endinterface

// ===== hdl/ntc_steinhart_hart_thermometer.sv =====
// Top level: configuration registers and the thermometer sequencer.
// One sample per transfer in, one temperature per transfer out. The sequencer runs a
// filter step, a resistance product, a normalize shift, 24 log squarings through the
// shared multiplier, four more products and a reciprocal division. The division is
// skipped for a non-positive or tiny denominator, and every step after the resistance
// product is skipped when the resistance is zero. The sample port is ready only between
// items; a finished result sits in an output register so the next sample can be taken
// while it waits, and a second finished result holds the sequencer until the first one
// is transferred.
module ntc_steinhart_hart_thermometer #(
    parameter int FILTER_DEPTH = nshh_pkg::FILTER_DEPTH_DEF,
    parameter int ADC_BITS     = nshh_pkg::ADC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nshh_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [nshh_pkg::CFG_W-1:0]  i_cfg_data,
    nshh_sample_if.sink                 i_sample,
    nshh_result_if.source               o_result
);
    import nshh_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coeff_a        <= '0;
            r_cfg.coeff_b        <= '0;
            r_cfg.coeff_c        <= '0;
            r_cfg.ohms_per_count <= OPC_RESET;
            r_cfg.offset_tenths  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEFF_A:        r_cfg.coeff_a        <= i_cfg_data;
                CFG_COEFF_B:        r_cfg.coeff_b        <= i_cfg_data;
                CFG_COEFF_C:        r_cfg.coeff_c        <= i_cfg_data;
                CFG_OHMS_PER_COUNT: r_cfg.ohms_per_count <= i_cfg_data[OPC_W-1:0];
                CFG_OFFSET_TENTHS:  r_cfg.offset_tenths  <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    nshh_ctrl #(
        .FILTER_DEPTH(FILTER_DEPTH),
        .ADC_BITS    (ADC_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_sample(i_sample),
        .o_result(o_result)
    );

endmodule

// ===== hdl/nshh_mul.sv =====
// Shared multi-cycle signed multiplier with right shift, truncation and saturation.
module nshh_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nshh_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import nshh_pkg::*;

    t_mul_state r_mstate, n_mstate;
    logic [63:0]     r_ma, r_mb, r_pp;
    logic            r_neg, r_short, r_done;
    logic [SH_W-1:0] r_sh;
    logic [1:0]      r_step;
    logic [127:0]    r_acc;
    logic signed [63:0] r_res;

    logic [31:0]  ha, hb;
    logic [127:0] addend, shifted;
    logic [62:0]  mag_r;

    always_comb begin
        n_mstate = r_mstate;
        unique case (r_mstate)
            M_IDLE: if (i_req.go) n_mstate = M_MUL;
            M_MUL:  n_mstate = M_ACC;
            M_ACC:  n_mstate = (r_short || r_step == 2'd3) ? M_FIN : M_MUL;
            M_FIN:  n_mstate = M_IDLE;
            default: n_mstate = M_IDLE;
        endcase
    end

    always_comb begin
        ha = r_step[1] ? r_ma[63:32] : r_ma[31:0];
        hb = r_step[0] ? r_mb[63:32] : r_mb[31:0];
        case (r_step)
            2'd0:    addend = {64'd0, r_pp};
            2'd3:    addend = {r_pp, 64'd0};
            default: addend = {32'd0, r_pp, 32'd0};
        endcase
        shifted = r_acc >> r_sh;
        mag_r   = (|shifted[127:63]) ? {63{1'b1}} : shifted[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_mstate <= n_mstate;
            r_done   <= (r_mstate == M_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_mstate)
            M_IDLE: begin
                if (i_req.go) begin
                    r_ma    <= nshh_mag(i_req.a);
                    r_mb    <= nshh_mag(i_req.b);
                    r_neg   <= i_req.a[63] ^ i_req.b[63];
                    r_short <= (nshh_mag(i_req.a) < 64'h1_0000_0000)
                            && (nshh_mag(i_req.b) < 64'h1_0000_0000);
                    r_sh    <= i_req.sh;
                    r_step  <= 2'd0;
                    r_acc   <= '0;
                end
            end
            M_MUL: r_pp <= 64'(ha) * 64'(hb);
            M_ACC: begin
                r_acc  <= r_acc + addend;
                r_step <= r_step + 2'd1;
            end
            M_FIN: r_res <= r_neg ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/nshh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module nshh_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nshh_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [nshh_pkg::QUO_W-1:0]  o_quo
);
    import nshh_pkg::*;

    logic [DVD_W-1:0]  r_dvd;
    logic [63:0]       r_rem, r_dsr;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;

    logic [63:0] t;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        t    = {r_rem[62:0], r_dvd[DVD_W-1]};
        diff = {1'b0, t} - {1'b0, r_dsr};
        ge   = !diff[64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_dvd <= i_req.dvd;
            r_dsr <= i_req.dsr;
            r_cnt <= i_req.steps;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[63:0] : t;
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/nshh_ctrl.sv =====
// Sequencer and datapath registers: filter, log, polynomial, reciprocal, output.
module nshh_ctrl #(
    parameter int FILTER_DEPTH = nshh_pkg::FILTER_DEPTH_DEF,
    parameter int ADC_BITS     = nshh_pkg::ADC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nshh_pkg::t_cfg   i_cfg,
    nshh_sample_if.sink      i_sample,
    nshh_result_if.source    o_result
);
    import nshh_pkg::*;

    localparam int NUM_W  = ADC_BITS + $clog2(FILTER_DEPTH);
    localparam int R_W    = ADC_BITS + OPC_W;
    localparam int P_W    = $clog2(R_W);
    localparam int FSH    = NUM_W + $clog2(FILTER_DEPTH);
    localparam int FRCP_W = NUM_W + 1;
    localparam int FPRD_W = NUM_W + FRCP_W;
    localparam logic [FRCP_W-1:0] FRCP =
        FRCP_W'(((longint'(1) << FSH) + longint'(FILTER_DEPTH) - longint'(1))
                / longint'(FILTER_DEPTH));

    t_state r_state, n_state;

    logic [NUM_W-1:0]    r_num;
    logic [ADC_BITS-1:0] r_level;
    logic [R_W-1:0]      r_r;
    logic [P_W-1:0]      r_p;
    logic [X_W-1:0]      r_x;
    logic [FRAC_W-1:0]   r_frac;
    logic [4:0]          r_cnt;
    logic signed [LN_W-1:0] r_ln;
    logic [SQ_W-1:0]     r_sq;
    logic signed [S_W-1:0] r_s;
    logic signed [63:0]  r_d;
    logic [QUO_W-1:0]    r_k;
    logic [TEMP_W-1:0]   r_pend_temp;
    logic                r_pend_oor;
    logic                r_issue, r_dgo;
    logic                r_o_valid;
    logic [TEMP_W-1:0]   r_o_temp;
    logic                r_o_oor;

    t_mul_req mul_req;
    t_div_req div_req;
    logic               mul_done, div_done;
    logic signed [63:0] mul_res;
    logic [QUO_W-1:0]   div_quo;

    logic        accept, slot_free, mul_state, div_state, sqr_last;
    logic [FPRD_W-1:0] fprod;
    logic [6:0]  pm;
    logic signed [64:0] dsum;
    logic signed [63:0] dsat;
    logic        d_le0, d_small;
    logic [31:0] y;
    logic [44:0] kx10, xmag;
    logic signed [KX_W-1:0] xv;
    logic [20:0] tq;
    logic signed [22:0] tsum;

    nshh_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    nshh_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    always_comb begin
        accept    = (r_state == ST_IDLE) && i_sample.valid;
        slot_free = !r_o_valid || o_result.ready;
        sqr_last  = (r_cnt == 5'd1);
        fprod     = FPRD_W'(r_num) * FPRD_W'(FRCP);
        pm        = 7'(r_p) - 7'd16;
        y         = mul_res[31:0];
        dsum      = 65'(i_cfg.coeff_a) + 65'(mul_res);
        if (dsum[64] != dsum[63]) begin
            dsat = dsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            dsat = dsum[63:0];
        end
        d_le0   = dsat[63] || (dsat == 64'd0);
        d_small = (dsat[62:30] == '0);
        kx10    = 45'(r_k) * 45'd10;
        xv      = $signed({1'b0, kx10}) - $signed(KELV_Q24);
        xmag    = xv[KX_W-1] ? 45'(-xv) : 45'(xv);
        tq      = xmag[44:24];
        tsum    = (xv[KX_W-1] ? -$signed({2'b00, tq}) : $signed({2'b00, tq}))
                + 23'(i_cfg.offset_tenths);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_sample.valid) n_state = ST_FILT;
            ST_FILT: n_state = ST_RMUL;
            ST_RMUL: if (mul_done) n_state = (mul_res == 64'd0) ? ST_FIN : ST_NORM;
            ST_NORM: if (r_r[R_W-1]) n_state = ST_SQR;
            ST_SQR:  if (mul_done && sqr_last) n_state = ST_LN;
            ST_LN:   if (mul_done) n_state = ST_SQ;
            ST_SQ:   if (mul_done) n_state = ST_CSQ;
            ST_CSQ:  if (mul_done) n_state = ST_SLN;
            ST_SLN: begin
                if (mul_done) begin
                    if (d_le0) n_state = ST_FIN;
                    else if (d_small) n_state = ST_TEMP;
                    else n_state = ST_DIV;
                end
            end
            ST_DIV:  if (div_done) n_state = ST_TEMP;
            ST_TEMP: n_state = ST_FIN;
            ST_FIN:  if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_sample.ready = (r_state == ST_IDLE);
        mul_state = (n_state == ST_RMUL) || (n_state == ST_SQR) || (n_state == ST_LN)
                 || (n_state == ST_SQ) || (n_state == ST_CSQ) || (n_state == ST_SLN);
        div_state = (n_state == ST_DIV);

        mul_req.go = r_issue;
        mul_req.a  = '0;
        mul_req.b  = '0;
        mul_req.sh = SH_NONE;
        unique case (r_state)
            ST_RMUL: begin
                mul_req.a = 64'(r_level);
                mul_req.b = 64'(i_cfg.ohms_per_count);
            end
            ST_SQR: begin
                mul_req.a  = 64'(r_x);
                mul_req.b  = 64'(r_x);
                mul_req.sh = SH_Q30;
            end
            ST_LN: begin
                mul_req.a  = 64'($signed({pm, r_frac}));
                mul_req.b  = LN2_Q30;
                mul_req.sh = SH_Q30;
            end
            ST_SQ: begin
                mul_req.a  = 64'(r_ln);
                mul_req.b  = 64'(r_ln);
                mul_req.sh = SH_Q24;
            end
            ST_CSQ: begin
                mul_req.a  = 64'(i_cfg.coeff_c);
                mul_req.b  = 64'(r_sq);
                mul_req.sh = SH_Q24;
            end
            ST_SLN: begin
                mul_req.a  = 64'(r_s);
                mul_req.b  = 64'(r_ln);
                mul_req.sh = SH_Q24;
            end
            default: ;
        endcase

        div_req.go    = r_dgo;
        div_req.dvd   = {1'b1, {(DVD_W-1){1'b0}}};
        div_req.dsr   = r_d;
        div_req.steps = RECIP_STEPS;

        o_result.valid        = r_o_valid;
        o_result.temp_tenths  = r_o_temp;
        o_result.out_of_range = r_o_oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= 1'b0;
            r_dgo     <= 1'b0;
            r_o_valid <= 1'b0;
            r_level   <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= mul_state && ((n_state != r_state) || mul_done);
            r_dgo   <= div_state && (n_state != r_state);
            if (r_state == ST_FILT) r_level <= fprod[FSH +: ADC_BITS];
            if (r_state == ST_FIN && slot_free) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_num <= NUM_W'(r_level) * NUM_W'(FILTER_DEPTH - 1)
                           + NUM_W'(i_sample.adc_sample);
                end
            end
            ST_RMUL: begin
                if (mul_done) begin
                    r_r         <= mul_res[R_W-1:0];
                    r_p         <= P_W'(R_W - 1);
                    r_pend_temp <= '0;
                    r_pend_oor  <= 1'b1;
                end
            end
            ST_NORM: begin
                if (r_r[R_W-1]) begin
                    r_x    <= r_r[R_W-1 -: X_W];
                    r_cnt  <= 5'(SQR_ITER);
                    r_frac <= '0;
                end else begin
                    r_r <= r_r << 1;
                    r_p <= r_p - P_W'(1);
                end
            end
            ST_SQR: begin
                if (mul_done) begin
                    r_frac <= {r_frac[FRAC_W-2:0], y[31]};
                    r_x    <= y[31] ? y[31:1] : y[30:0];
                    r_cnt  <= r_cnt - 5'd1;
                end
            end
            ST_LN:  if (mul_done) r_ln <= mul_res[LN_W-1:0];
            ST_SQ:  if (mul_done) r_sq <= mul_res[SQ_W-1:0];
            ST_CSQ: if (mul_done) r_s <= S_W'(i_cfg.coeff_b) + mul_res[S_W-1:0];
            ST_SLN: begin
                if (mul_done) begin
                    r_d <= dsat;
                    r_k <= K_CLAMP;
                end
            end
            ST_DIV: if (div_done) r_k <= div_quo;
            ST_TEMP: begin
                if (tsum > 23'sd32767) begin
                    r_pend_temp <= 16'h7FFF;
                    r_pend_oor  <= 1'b1;
                end else if (tsum < -23'sd32768) begin
                    r_pend_temp <= 16'h8000;
                    r_pend_oor  <= 1'b1;
                end else begin
                    r_pend_temp <= tsum[TEMP_W-1:0];
                    r_pend_oor  <= 1'b0;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    r_o_temp <= r_pend_temp;
                    r_o_oor  <= r_pend_oor;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== test/ntc_steinhart_hart_thermometer_chk.sv =====
// Checker: watches the sample and result channels, predicts temperatures and compares.
module ntc_steinhart_hart_thermometer_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nshh_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [nshh_pkg::CFG_W-1:0]  i_cfg_data,
    nshh_sample_if.sink                 i_sample,
    nshh_result_if.sink                 i_result,
    output int                          o_fail_cnt,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import nshh_pkg::*;

    typedef struct packed {
        logic [15:0] temp_tenths;
        logic        out_of_range;
    } t_temp;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    logic signed [47:0] a_q46, b_q46, c_q46;
    logic [23:0]        opc_q16;
    logic signed [15:0] ofs;
    logic [11:0]        level;
    t_temp              temp_q[$];

    function automatic longint mul_trunc(longint a, longint b, int s);
        logic [127:0] p;
        logic [127:0] r;
        logic [63:0]  ua, ub;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua  = a < 0 ? -a : a;
        ub  = b < 0 ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        r   = p >> s;
        if (r > 128'(I64_MAX)) r = 128'(I64_MAX);
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] t;
        t = 65'(a) + 65'(b);
        if (t > 65'(I64_MAX)) return I64_MAX;
        if (t < 65'(I64_MIN)) return I64_MIN;
        return longint'(t);
    endfunction

    function automatic longint ln_of_ohms(logic [63:0] r);
        int          p;
        logic [63:0] x, frac;
        logic [127:0] sqr;
        longint      l2;
        p = 0;
        frac = 0;
        for (int i = 0; i < 64; i++) if (r[i]) p = i;
        x = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
        for (int i = 0; i < 24; i++) begin
            sqr = {64'd0, x} * {64'd0, x};
            x = 64'(sqr >> 30);
            frac = frac << 1;
            if (x >= 64'h8000_0000) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = longint'(p - 16) * 16777216 + longint'(frac);
        return mul_trunc(l2, 744261118, 30);
    endfunction

    function automatic t_temp predict_temp(logic [11:0] sample);
        t_temp       res;
        logic [63:0] r, ud, k;
        longint      ln, sq, s, d, x, tenths;
        level = 12'(({4'd0, level} * 16'd7 + {4'd0, sample}) / 16'd8);
        res = '{16'd0, 1'b1};
        r = 64'(level) * 64'(opc_q16);
        if (r == 0) return res;
        ln = ln_of_ohms(r);
        sq = mul_trunc(ln, ln, 24);
        s  = add_sat(longint'(b_q46), mul_trunc(longint'(c_q46), sq, 24));
        d  = add_sat(longint'(a_q46), mul_trunc(s, ln, 24));
        if (d <= 0) return res;
        ud = 64'(d);
        if (ud < 128) k = 64'h100_0000_0000;
        else k = 64'((128'd1 << 70) / {64'd0, ud});
        if (k > 64'h100_0000_0000) k = 64'h100_0000_0000;
        x = longint'(k * 10) - longint'(27315) * 8388608;
        tenths = (x >= 0) ? (x >>> 24) : -((-x) >>> 24);
        tenths += longint'(ofs);
        res.out_of_range = 1'b0;
        if (tenths > 32767) begin tenths = 32767; res.out_of_range = 1'b1; end
        if (tenths < -32768) begin tenths = -32768; res.out_of_range = 1'b1; end
        res.temp_tenths = tenths[15:0];
        return res;
    endfunction

    assign o_pending = temp_q.size();

    always_ff @(posedge i_clk) begin
        t_temp want;
        if (!i_rst_n) begin
            a_q46 <= '0; b_q46 <= '0; c_q46 <= '0;
            opc_q16 <= OPC_RESET; ofs <= '0; level = '0;
            o_fail_cnt <= 0;
            temp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COEFF_A:        a_q46 <= i_cfg_data[47:0];
                    CFG_COEFF_B:        b_q46 <= i_cfg_data[47:0];
                    CFG_COEFF_C:        c_q46 <= i_cfg_data[47:0];
                    CFG_OHMS_PER_COUNT: opc_q16 <= i_cfg_data[23:0];
                    CFG_OFFSET_TENTHS:  ofs <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready)
                temp_q.push_back(predict_temp(i_sample.adc_sample));
            if (i_result.valid && i_result.ready) begin
                if (temp_q.size() == 0) begin
                    $display("%0t unexpected result temp=%h oor=%b", $time,
                             i_result.temp_tenths, i_result.out_of_range);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = temp_q.pop_front();
                    if (want.temp_tenths !== i_result.temp_tenths ||
                        want.out_of_range !== i_result.out_of_range) begin
                        $display("%0t mismatch: expected temp=%h oor=%b, actual temp=%h oor=%b",
                                 $time, want.temp_tenths, want.out_of_range,
                                 i_result.temp_tenths, i_result.out_of_range);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/ntc_steinhart_hart_thermometer_tb.sv =====
// Testbench top: drives samples and register writes, stalls the result side, gives the verdict.
module ntc_steinhart_hart_thermometer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nshh_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   fail_cnt;
    int                   pending;
    int                   cycle_cnt;
    logic                 calm;
    logic                 hold_off;

    nshh_sample_if samp_if ();
    nshh_result_if res_if ();

    ntc_steinhart_hart_thermometer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_sample(samp_if.sink), .o_result(res_if.source)
    );

    ntc_steinhart_hart_thermometer_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_sample(samp_if), .i_result(res_if),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A typical 10k NTC coefficient set in Q46, plus extremes.
    localparam longint A_TYP = 64'd60_000_000_000;
    localparam longint B_TYP = 64'd16_000_000_000;
    localparam longint C_TYP = 64'd6_000_000;

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 3_000_000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold-off, none at the end.
    initial begin
        int n;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off) begin
                res_if.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [11:0] v);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            samp_if.valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
        samp_if.valid      <= 1'b1;
        samp_if.adc_sample <= v;
        @(posedge i_clk);
        while (!samp_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        samp_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_all(longint a, longint b, longint c, logic [23:0] opc, logic [15:0] o);
        write_reg(CFG_COEFF_A, 48'(a));
        write_reg(CFG_COEFF_B, 48'(b));
        write_reg(CFG_COEFF_C, 48'(c));
        write_reg(CFG_OHMS_PER_COUNT, 48'(opc));
        write_reg(CFG_OFFSET_TENTHS, 48'(o));
    endtask

    initial begin
        calm = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        samp_if.valid <= 1'b0;
        samp_if.adc_sample <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: zero denominator, and zero level.
        send_sample(12'd0);
        send_sample(12'hFFF);
        drain();

        set_all(A_TYP, B_TYP, C_TYP, OPC_RESET, 16'd0);
        send_sample(12'd0);
        for (int i = 0; i < 8; i++) send_sample(12'hFFF);
        send_sample(12'd1);
        send_sample(12'd2048);
        drain();
        // Zero ohms per count, negative denominator, tiny denominator with offsets.
        write_reg(CFG_OHMS_PER_COUNT, 48'd0);
        send_sample(12'd1000);
        drain();
        set_all(-A_TYP, 0, 0, 24'hFFFFFF, 16'h7FFF);
        send_sample(12'd3000);
        drain();
        set_all(64'd5, 0, 0, 24'd1, 16'h8000);
        send_sample(12'd4095);
        drain();
        write_reg(CFG_OFFSET_TENTHS, 48'h7FFF);
        send_sample(12'd4095);
        drain();
        set_all(64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 24'hFFFFFF,
                16'd0);
        send_sample(12'd77);
        drain();
        set_all(64'hFFFF_8000_0000_0000, 64'hFFFF_8000_0000_0000, 64'hFFFF_8000_0000_0000,
                24'd1, 16'h8000);
        send_sample(12'd500);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= 3'd7;
        i_cfg_data <= '1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(A_TYP, B_TYP, C_TYP, OPC_RESET, 16'd0);
                1: set_all(A_TYP + $urandom_range(0, 1 << 30), B_TYP, C_TYP * 2,
                           24'($urandom_range(1, 24'hFFFFFF)), 16'($urandom));
                2: set_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           24'($urandom), 16'($urandom));
                3: set_all(A_TYP / 2, B_TYP / 3, C_TYP, 24'($urandom_range(1, 2000)),
                           16'($urandom_range(0, 2000)));
                4: set_all(A_TYP, B_TYP, 0, 24'hFFFFFF, 16'hF000);
                default: set_all(A_TYP, B_TYP, C_TYP, 24'($urandom_range(100000, 900000)),
                                 16'd5);
            endcase
            if (ph == 5) calm = 1'b1;
            for (int i = 0; i < 150; i++) begin
                if (ph == 1 && i == 20) hold_off = 1'b1;
                send_sample($urandom_range(0, 3) == 0 ? 12'($urandom) :
                            12'($urandom_range(1500, 2600)));
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
